// File: sv/spb_pkg.sv
package spb_pkg;

  localparam int MaxCodeBits = 24;
  localparam int ValueW      = 16;
  localparam int LenW        = 5;
  localparam int PendW       = 7;
  localparam int CntW        = 3;
  localparam int AccW        = PendW + MaxCodeBits;
  localparam int AlignW      = AccW + 1;
  localparam int WidthW      = $clog2(AccW + 1);
  localparam int MaxBytes    = AccW / 8;
  localparam int NbW         = $clog2(MaxBytes + 1);
  localparam int IdxW        = $clog2(MaxBytes);
  localparam int QueueDepth  = 2;
  localparam int QPtrW       = $clog2(QueueDepth);
  localparam int QCntW       = $clog2(QueueDepth + 1);

  localparam logic [7:0] StuffMarker = 8'hFF;
  localparam logic [7:0] StuffByte   = 8'h00;

  typedef enum logic {
    KindAppend = 1'b0,
    KindFlush  = 1'b1
  } kind_e;

  typedef enum logic {
    BkData  = 1'b0,
    BkStuff = 1'b1
  } back_state_e;

  typedef struct packed {
    logic              kind;
    logic [ValueW-1:0] code_value;
    logic [LenW-1:0]   code_length;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_word_t;

  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [NbW-1:0]           nbytes;
  } job_t;

  typedef struct packed {
    logic valid;
    logic ready;
  } hs_t;

endpackage

// File: sv/spb_front.sv
module spb_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  spb_pkg::in_word_t in_word_i,
  output spb_pkg::job_t     job_o,
  output spb_pkg::hs_t      push_o,
  input  logic              q_ready_i
);
  import spb_pkg::*;

  logic [PendW-1:0]  pend_q, pend_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [LenW-1:0]   len_sat;
  logic [ValueW-1:0] val_m;
  logic [AccW-1:0]   acc;
  logic [WidthW-1:0] width;
  logic [WidthW-1:0] shamt;
  logic [AlignW-1:0] aligned;
  logic [7:0]        fl_byte;
  logic              accept;
  logic              has_bytes;

  assign in_ready_o = q_ready_i;
  assign accept     = in_valid_i && q_ready_i;

  always_comb begin
    len_sat = (in_word_i.code_length > LenW'(MaxCodeBits)) ? LenW'(MaxCodeBits)
                                                           : in_word_i.code_length;
    for (int i = 0; i < ValueW; i++) begin
      val_m[i] = in_word_i.code_value[i] & (LenW'(i) < len_sat);
    end
    acc     = (AccW'(pend_q) << len_sat) | AccW'(val_m);
    width   = WidthW'(cnt_q) + WidthW'(len_sat);
    shamt   = WidthW'(AlignW) - width;
    aligned = {1'b0, acc} << shamt;
    fl_byte = 8'({1'b0, pend_q} << (4'd8 - 4'(cnt_q)));
  end

  always_comb begin
    job_o     = '0;
    pend_d    = pend_q;
    cnt_d     = cnt_q;
    has_bytes = 1'b0;
    if (in_word_i.kind == KindFlush) begin
      job_o.bytes[0] = fl_byte;
      job_o.nbytes   = NbW'(1);
      has_bytes      = (cnt_q != '0);
      pend_d         = '0;
      cnt_d          = '0;
    end else begin
      for (int i = 0; i < MaxBytes; i++) begin
        job_o.bytes[i] = aligned[AlignW-1-8*i -: 8];
      end
      job_o.nbytes = NbW'(width >> 3);
      has_bytes    = (width >> 3) != '0;
      cnt_d        = width[CntW-1:0];
      pend_d       = PendW'(acc) & ~({PendW{1'b1}} << width[CntW-1:0]);
    end
    push_o.valid = in_valid_i && has_bytes;
    push_o.ready = q_ready_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      cnt_q  <= '0;
    end else if (accept) begin
      pend_q <= pend_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

// File: sv/spb_queue.sv
module spb_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  spb_pkg::job_t push_job_i,
  output logic          ready_o,
  output logic          valid_o,
  output spb_pkg::job_t head_o,
  input  logic          pop_i
);
  import spb_pkg::*;

  job_t             mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QCntW-1:0] cnt_q;
  logic             do_push, do_pop;

  assign ready_o = cnt_q != QCntW'(QueueDepth);
  assign valid_o = cnt_q != '0;
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  function automatic logic [QPtrW-1:0] next_ptr(input logic [QPtrW-1:0] p);
    next_ptr = (p == QPtrW'(QueueDepth - 1)) ? '0 : p + QPtrW'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= next_ptr(wr_q);
      end
      if (do_pop) begin
        rd_q <= next_ptr(rd_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + QCntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - QCntW'(1);
      end
    end
  end

endmodule

// File: sv/spb_back.sv
module spb_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               head_valid_i,
  input  spb_pkg::job_t      head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output spb_pkg::out_word_t out_word_o
);
  import spb_pkg::*;

  back_state_e     state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            out_valid_q, out_valid_d;
  out_word_t       out_q;
  out_word_t       cur;
  logic            can_load, fire, is_ff, last_idx;

  assign can_load    = !out_valid_q || out_ready_i;
  assign fire        = head_valid_i && can_load;
  assign is_ff       = head_i.bytes[idx_q] == StuffMarker;
  assign last_idx    = NbW'(idx_q) == head_i.nbytes - NbW'(1);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BkData: begin
        if (fire && is_ff) begin
          state_d = BkStuff;
        end
      end
      BkStuff: begin
        if (fire) begin
          state_d = BkData;
        end
      end
      default: state_d = BkData;
    endcase
  end

  // outputs
  always_comb begin
    cur = '0;
    case (state_q)
      BkData: begin
        cur.out_byte = head_i.bytes[idx_q];
        cur.last     = last_idx && !is_ff;
      end
      BkStuff: begin
        cur.out_byte = StuffByte;
        cur.last     = last_idx;
      end
      default: cur = '0;
    endcase
    pop_o       = fire && cur.last;
    out_valid_d = can_load ? head_valid_i : out_valid_q;
    idx_d       = idx_q;
    if (pop_o) begin
      idx_d = '0;
    end else if (fire && !(state_q == BkData && is_ff)) begin
      idx_d = idx_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BkData;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= cur;
    end
  end

endmodule

// File: sv/stuffed_bit_packer_top.sv
// channel | valid      | ready       | word
// in      | in_valid_i | in_ready_o  | in_word_i  (kind, code_value, code_length)
// out     | out_valid_o| out_ready_i | out_word_o (out_byte, last)
//
// The front takes one word per cycle while the two-entry job queue has room.
// The back emits one byte per cycle from a registered output when out_ready_i
// allows; each 0xFF among a word's 0 to 3 bytes is followed by a stuffed 0x00.
// Reset clears the pending bits, the queue and the output valid flag.
// Either side may stall; the queue decouples them.
module stuffed_bit_packer_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  spb_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output spb_pkg::out_word_t out_word_o
);
  import spb_pkg::*;

  job_t push_job, head_job;
  hs_t  push_hs;
  logic q_ready, head_valid, pop;

  spb_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .job_o      (push_job),
    .push_o     (push_hs),
    .q_ready_i  (q_ready)
  );

  spb_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push_hs.valid && push_hs.ready),
    .push_job_i (push_job),
    .ready_o    (q_ready),
    .valid_o    (head_valid),
    .head_o     (head_job),
    .pop_i      (pop)
  );

  spb_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head_job),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_word_o   (out_word_o)
  );

endmodule
